>>> design/dwepm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dwepm_pkg;

    // Request codes carried by the input word.
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_EDGE_R = 2'd1;
    localparam logic [1:0] REQ_EDGE_L = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd4;

    // Field widths.
    localparam int TGT_W  = 16;
    localparam int GAIN_W = 11;
    localparam int DUTY_W = 8;
    localparam int ACC_W  = 32;

    // Integral saturates at the largest positive 32-bit value.
    localparam logic [ACC_W-1:0] ACC_MAX = 32'h7FFF_FFFF;

    // Tuning values shared by both wheels.
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [DUTY_W-1:0]        base_speed;
        logic [DUTY_W-1:0]        speed_limit;
    } t_gains;

    // Per-wheel command from the sequencing logic.
    typedef struct packed {
        logic                    load;
        logic                    count_up;
        logic                    run;
        logic signed [TGT_W-1:0] target;
    } t_wheel_cmd;

    // Per-wheel status and proposed drive.
    typedef struct packed {
        logic              short_of_goal;
        logic [DUTY_W-1:0] duty;
        logic              fwd;
        logic              rev;
    } t_wheel_stat;

endpackage

`default_nettype wire

>>> design/dual_wheel_encoder_pid_move.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Word
// -------   ---------  -------------------------  ---------------------------------
// input     in         i_in_valid / o_in_ready    i_req_type, i_target_right/left
// output    out        o_out_valid / i_out_ready  o_right_*, o_left_*, o_busy_res
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word is accepted per cycle. Each word is held in the input register until it
// advances, and its result is then written to the output register.
// The PID sum for both wheels is formed combinationally between the two registers.
// A stalled output holds the input register; a new word is still taken when the output
// is consumed in the same cycle. Reset is synchronous, sparing the input data word.

module dual_wheel_encoder_pid_move
    import dwepm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output      logic                    o_in_ready,
    input  wire logic [1:0]              i_req_type,
    input  wire logic signed [TGT_W-1:0] i_target_right,
    input  wire logic signed [TGT_W-1:0] i_target_left,
    output      logic                    o_out_valid,
    input  wire logic                    i_out_ready,
    output      logic [DUTY_W-1:0]       o_right_duty,
    output      logic                    o_right_fwd,
    output      logic                    o_right_rev,
    output      logic [DUTY_W-1:0]       o_left_duty,
    output      logic                    o_left_fwd,
    output      logic                    o_left_rev,
    output      logic                    o_busy_res,
    input  wire logic                    i_cfg_valid,
    output      logic                    o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic                    r_in_valid;
    logic [1:0]              r_req;
    logic signed [TGT_W-1:0] r_tgt_r;
    logic signed [TGT_W-1:0] r_tgt_l;

    t_gains r_gains;

    logic              r_out_valid;
    logic              r_moving;
    logic [DUTY_W-1:0] r_right_duty;
    logic              r_right_fwd;
    logic              r_right_rev;
    logic [DUTY_W-1:0] r_left_duty;
    logic              r_left_fwd;
    logic              r_left_rev;

    logic        advance;
    logic        any_short;
    t_wheel_cmd  cmd_r;
    t_wheel_cmd  cmd_l;
    t_wheel_stat stat_r;
    t_wheel_stat stat_l;

    // The input register moves on when the output slot is free or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req   <= i_req_type;
            r_tgt_r <= i_target_right;
            r_tgt_l <= i_target_left;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.gain_p      <= 11'sd1;
            r_gains.gain_i      <= '0;
            r_gains.gain_d      <= '0;
            r_gains.base_speed  <= '0;
            r_gains.speed_limit <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GAIN_P: r_gains.gain_p      <= i_cfg_data;
                CFG_GAIN_I: r_gains.gain_i      <= i_cfg_data;
                CFG_GAIN_D: r_gains.gain_d      <= i_cfg_data;
                CFG_BASE:   r_gains.base_speed  <= i_cfg_data[DUTY_W-1:0];
                CFG_LIMIT:  r_gains.speed_limit <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Commands to the two wheels.
    assign any_short = stat_r.short_of_goal || stat_l.short_of_goal;

    always_comb begin
        cmd_r.load     = advance && (r_req == REQ_START);
        cmd_r.count_up = advance && r_moving && (r_req == REQ_EDGE_R);
        cmd_r.run      = advance && r_moving && (r_req == REQ_TICK) && any_short;
        cmd_r.target   = r_tgt_r;
        cmd_l.load     = cmd_r.load;
        cmd_l.count_up = advance && r_moving && (r_req == REQ_EDGE_L);
        cmd_l.run      = cmd_r.run;
        cmd_l.target   = r_tgt_l;
    end

    dwepm_wheel u_wheel_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gains (r_gains),
        .i_cmd   (cmd_r),
        .o_stat  (stat_r)
    );

    dwepm_wheel u_wheel_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gains (r_gains),
        .i_cmd   (cmd_l),
        .o_stat  (stat_l)
    );

    // Move state and bridge drive; these registers are also the result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving     <= 1'b0;
            r_right_duty <= '0;
            r_right_fwd  <= 1'b0;
            r_right_rev  <= 1'b0;
            r_left_duty  <= '0;
            r_left_fwd   <= 1'b0;
            r_left_rev   <= 1'b0;
        end else if (advance) begin
            if (r_req == REQ_START) begin
                if ((r_tgt_r == '0) && (r_tgt_l == '0)) begin
                    r_moving     <= 1'b0;
                    r_right_duty <= '0;
                    r_right_fwd  <= 1'b0;
                    r_right_rev  <= 1'b0;
                    r_left_duty  <= '0;
                    r_left_fwd   <= 1'b0;
                    r_left_rev   <= 1'b0;
                end else begin
                    r_moving <= 1'b1;
                end
            end else if ((r_req == REQ_TICK) && r_moving) begin
                if (any_short) begin
                    r_right_duty <= stat_r.duty;
                    r_right_fwd  <= stat_r.fwd;
                    r_right_rev  <= stat_r.rev;
                    r_left_duty  <= stat_l.duty;
                    r_left_fwd   <= stat_l.fwd;
                    r_left_rev   <= stat_l.rev;
                end else begin
                    r_moving     <= 1'b0;
                    r_right_duty <= '0;
                    r_right_fwd  <= 1'b0;
                    r_right_rev  <= 1'b0;
                    r_left_duty  <= '0;
                    r_left_fwd   <= 1'b0;
                    r_left_rev   <= 1'b0;
                end
            end
        end
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_right_duty = r_right_duty;
    assign o_right_fwd  = r_right_fwd;
    assign o_right_rev  = r_right_rev;
    assign o_left_duty  = r_left_duty;
    assign o_left_fwd   = r_left_fwd;
    assign o_left_rev   = r_left_rev;
    assign o_busy_res   = r_moving;

    // With no move in progress the motors are stopped.
    a_idle_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_moving |-> ((r_right_duty == '0) && !r_right_fwd && !r_right_rev
                       && (r_left_duty == '0) && !r_left_fwd && !r_left_rev))
        else $error("motors driven while idle");

    // A bridge is never driven both ways, and reverse always carries duty.
    a_bridge_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_right_fwd && r_right_rev) && !(r_left_fwd && r_left_rev)
        && (!r_right_rev || (r_right_duty != '0)) && (!r_left_rev || (r_left_duty != '0)))
        else $error("illegal bridge drive");

    // Every word that leaves the input register produces a result next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result lost");

    // Right-wheel drive set by a tick never exceeds the speed limit.
    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(advance) && $stable(r_gains.speed_limit)
        |-> (r_right_duty <= r_gains.speed_limit) || !r_moving
            || ($past(r_req) != REQ_TICK))
        else $error("duty above limit");

endmodule

`default_nettype wire

>>> design/dwepm_wheel.sv
`timescale 1ns / 1ps
`default_nettype none

module dwepm_wheel
    import dwepm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_gains      i_gains,
    input  wire t_wheel_cmd  i_cmd,
    output t_wheel_stat      o_stat
);

    logic [TGT_W-1:0] r_goal;
    logic             r_back;
    logic [TGT_W-1:0] r_count;
    logic [ACC_W-1:0] r_accum;
    logic [TGT_W-1:0] r_prev;

    logic                       is_short;
    logic [TGT_W-1:0]           err;
    logic [TGT_W-1:0]           tgt_mag;
    logic [ACC_W-1:0]           acc_sum;
    logic [ACC_W-1:0]           acc_new;
    logic signed [TGT_W:0]      err_s;
    logic signed [TGT_W+1:0]    diff_s;
    logic signed [ACC_W:0]      acc_s;
    logic signed [27:0]         p_term;
    logic signed [43:0]         i_term;
    logic signed [28:0]         d_term;
    logic signed [45:0]         pid_sum;
    logic [DUTY_W-1:0]          duty;

    // Magnitude of the signed target; the most negative value maps to 0x8000.
    assign tgt_mag = i_cmd.target[TGT_W-1] ? (~i_cmd.target + 1'b1) : i_cmd.target;

    // Remaining error and the saturated integral for this control tick.
    assign is_short = r_goal > r_count;
    assign err      = r_goal - r_count;
    assign acc_sum  = r_accum + {{(ACC_W-TGT_W){1'b0}}, err};
    assign acc_new  = acc_sum[ACC_W-1] ? ACC_MAX : acc_sum;

    // PID terms: one multiply per term, then a single sum.
    always_comb begin
        err_s   = $signed({1'b0, err});
        diff_s  = $signed({2'b00, err}) - $signed({2'b00, r_prev});
        acc_s   = $signed({1'b0, acc_new});
        p_term  = err_s * i_gains.gain_p;
        i_term  = acc_s * i_gains.gain_i;
        d_term  = diff_s * i_gains.gain_d;
        pid_sum = $signed({38'b0, i_gains.base_speed}) + 46'(p_term)
                + 46'(i_term) + 46'(d_term);
    end

    // Clamp to the range zero to the speed limit.
    always_comb begin
        duty = '0;
        if (is_short) begin
            if (pid_sum < 0) begin
                duty = '0;
            end else if (pid_sum > $signed({38'b0, i_gains.speed_limit})) begin
                duty = i_gains.speed_limit;
            end else begin
                duty = pid_sum[DUTY_W-1:0];
            end
        end
    end

    // A stopped wheel shows forward on the bridge.
    always_comb begin
        o_stat.short_of_goal = is_short;
        o_stat.duty          = duty;
        o_stat.rev           = (duty != '0) && r_back;
        o_stat.fwd           = !((duty != '0) && r_back);
    end

    // Wheel state: target, tick counter and PID memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal  <= '0;
            r_back  <= 1'b0;
            r_count <= '0;
            r_accum <= '0;
            r_prev  <= '0;
        end else if (i_cmd.load) begin
            r_goal  <= tgt_mag;
            r_back  <= i_cmd.target[TGT_W-1];
            r_count <= '0;
            r_accum <= '0;
            r_prev  <= '0;
        end else if (i_cmd.count_up) begin
            if (r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
        end else if (i_cmd.run && is_short) begin
            r_accum <= acc_new;
            r_prev  <= err;
        end
    end

    // The integral never goes negative and never passes its ceiling.
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_accum[ACC_W-1])
        else $error("integral left its range");

    // A wheel that reached its goal never proposes a nonzero duty.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_short |-> (duty == '0))
        else $error("duty on a finished wheel");

    // A count step never moves the counter backward.
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.count_up && !i_cmd.load) |=> (r_count >= $past(r_count)))
        else $error("tick counter went backward");

endmodule

`default_nettype wire
